// ----- rtl/core/qgft_pkg.sv -----
// ----------------------------------------------------------------------------
// qgft_pkg
// Shared types and constants of the gait foot trajectory block.
// ----------------------------------------------------------------------------
package qgft_pkg;

  localparam int NUM_LEGS_DEF = 4;

  // register indexes
  localparam logic [2:0] REG_PHASE_INC = 3'd0;
  localparam logic [2:0] REG_SWING     = 3'd1;
  localparam logic [2:0] REG_STEP_LEN  = 3'd2;
  localparam logic [2:0] REG_LIFT_H    = 3'd3;
  localparam logic [2:0] REG_START0    = 3'd4;
  localparam logic [2:0] REG_START1    = 3'd5;
  localparam logic [2:0] REG_START2    = 3'd6;
  localparam logic [2:0] REG_START3    = 3'd7;

  // reset values
  localparam logic [15:0] RST_PHASE_INC = 16'd328;
  localparam logic [15:0] RST_SWING     = 16'd16384;
  localparam logic [15:0] RST_STEP_LEN  = 16'd10240;
  localparam logic [15:0] RST_LIFT_H    = 16'd5120;
  localparam logic [15:0] RST_START0    = 16'd0;
  localparam logic [15:0] RST_START1    = 16'd16384;
  localparam logic [15:0] RST_START2    = 16'd32768;
  localparam logic [15:0] RST_START3    = 16'd49152;

  // step counts of the shared unit
  localparam logic [5:0] MUL_STEPS  = 6'd34;
  localparam logic [5:0] DIV_STEPS  = 6'd34;
  localparam logic [5:0] SQRT_STEPS = 6'd32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } eng_op_t;

  // command to the shared unit
  // mul: a multiplier, b multiplicand; div: a numerator (34 bit), b divisor;
  // sqrt: a radicand
  typedef struct packed {
    eng_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } eng_cmd_t;

endpackage

// ----- rtl/core/qgft_engine.sv -----
// ----------------------------------------------------------------------------
// qgft_engine
// Iterative shift-add multiply, restoring divide and digit-by-digit square
// root around a single shared add/subtract unit, one bit per cycle.
// ----------------------------------------------------------------------------
module qgft_engine
  import qgft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  eng_cmd_t    cmd,
  output logic        done,
  output logic [63:0] result
);

  logic        busy;
  eng_op_t     op_r;
  logic [65:0] acc;
  logic [65:0] x;
  logic [63:0] y;
  logic [5:0]  cnt;

  logic [65:0] a_in;
  logic [65:0] b_in;
  logic        sub;
  logic [66:0] sum;
  logic        take;

  // operand selection for the shared adder
  always_comb begin
    unique case (op_r)
      OP_MUL: begin
        a_in = acc;
        b_in = x;
        sub  = 1'b0;
      end
      OP_DIV: begin
        a_in = {acc[64:0], y[33]};
        b_in = x;
        sub  = 1'b1;
      end
      OP_SQRT: begin
        a_in = {acc[63:0], y[63:62]};
        b_in = {x[63:0], 2'b01};
        sub  = 1'b1;
      end
      default: begin
        a_in = acc;
        b_in = x;
        sub  = 1'b0;
      end
    endcase
    sum  = {1'b0, a_in} + {1'b0, (sub ? ~b_in : b_in)} + {66'd0, sub};
    take = sub ? sum[66] : y[0];
  end

  // sequencing of the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= OP_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        op_r <= cmd.op;
        acc  <= '0;
        x    <= (cmd.op == OP_SQRT) ? 66'd0 : {2'b00, cmd.b};
        y    <= cmd.a;
        unique case (cmd.op)
          OP_MUL:  cnt <= MUL_STEPS;
          OP_DIV:  cnt <= DIV_STEPS;
          OP_SQRT: cnt <= SQRT_STEPS;
          default: cnt <= MUL_STEPS;
        endcase
      end else if (busy) begin
        unique case (op_r)
          OP_MUL: begin
            if (take) acc <= sum[65:0];
            x <= {x[64:0], 1'b0};
            y <= {1'b0, y[63:1]};
          end
          OP_DIV: begin
            acc <= take ? sum[65:0] : a_in;
            y   <= {y[62:0], take};
          end
          OP_SQRT: begin
            acc <= take ? sum[65:0] : a_in;
            x   <= {x[64:0], take};
            y   <= {y[61:0], 2'b00};
          end
          default: ;
        endcase
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // result view of the working registers
  always_comb begin
    unique case (op_r)
      OP_MUL:  result = acc[63:0];
      OP_DIV:  result = {30'd0, y[33:0]};
      OP_SQRT: result = x[63:0];
      default: result = acc[63:0];
    endcase
  end

endmodule

// ----- rtl/core/quadruped_gait_foot_trajectory.sv -----
// ----------------------------------------------------------------------------
// quadruped_gait_foot_trajectory
// Phase based gait generator: per tick, one stride offset and lift per leg.
// ----------------------------------------------------------------------------
// Each accepted item with tick set advances the gait phase and then emits one
// item per leg, legs in order, the last one flagged by m_tlast; an item with
// tick clear is taken and produces nothing. The multiplies, divides and square
// roots run one bit per cycle through the shared unit in qgft_engine, which
// takes its step count (34 for a multiply or a divide, 32 for a square root)
// for each operation. A tick first computes the squared lift height. Each
// stance leg then takes a setup state, a multiply, a divide and an emit
// state. Each swing leg takes setup, three multiplies, a square root, two
// divides and emit. A leg sitting exactly at the start of a zero width swing
// window takes only setup and emit. A leg item may also wait in the emit
// state for m_tready. With the reset gait one leg swings and three stand,
// unless two legs sit on a window edge. s_tready is high only between ticks.
// Configuration is to be written through the APB port only while idle; the
// block itself leaves this unchecked.
// ----------------------------------------------------------------------------
module quadruped_gait_foot_trajectory
  import qgft_pkg::*;
#(
  parameter int NUM_LEGS = NUM_LEGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [0] tick
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [1:0] leg, [17:2] stride_offset, [33:18] lift,
                                // [34] swinging
  output logic        m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_H2,
    S_LEG,
    S_PMUL,
    S_QMUL,
    S_ROOT,
    S_LDIV,
    S_SMUL,
    S_SDIV,
    S_EMIT
  } state_t;

  localparam logic [1:0] LAST_LEG = 2'(NUM_LEGS - 1);

  // configuration registers
  logic [15:0] phase_increment;
  logic [15:0] swing_fraction;
  logic [15:0] step_length;
  logic [15:0] lift_height;
  logic [15:0] start_leg [4];

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= RST_PHASE_INC;
      swing_fraction  <= RST_SWING;
      step_length     <= RST_STEP_LEN;
      lift_height     <= RST_LIFT_H;
      start_leg[0]    <= RST_START0;
      start_leg[1]    <= RST_START1;
      start_leg[2]    <= RST_START2;
      start_leg[3]    <= RST_START3;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PHASE_INC: phase_increment <= pwdata[15:0];
        REG_SWING:     swing_fraction  <= pwdata[15:0];
        REG_STEP_LEN:  step_length     <= pwdata[15:0];
        REG_LIFT_H:    lift_height     <= pwdata[15:0];
        REG_START0:    start_leg[0]    <= pwdata[15:0];
        REG_START1:    start_leg[1]    <= pwdata[15:0];
        REG_START2:    start_leg[2]    <= pwdata[15:0];
        REG_START3:    start_leg[3]    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[4:2])
      REG_PHASE_INC: prdata = {16'd0, phase_increment};
      REG_SWING:     prdata = {16'd0, swing_fraction};
      REG_STEP_LEN:  prdata = {16'd0, step_length};
      REG_LIFT_H:    prdata = {16'd0, lift_height};
      REG_START0:    prdata = {16'd0, start_leg[0]};
      REG_START1:    prdata = {16'd0, start_leg[1]};
      REG_START2:    prdata = {16'd0, start_leg[2]};
      REG_START3:    prdata = {16'd0, start_leg[3]};
      default:       prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_t      state;
  logic [15:0] gait_phase;
  logic [1:0]  leg;
  logic        issued;
  logic [31:0] h2;
  logic [63:0] res;
  logic [15:0] d_r;
  logic        swing_r;
  logic        neg_r;
  logic [16:0] mag_r;
  logic [17:0] den_r;
  logic [15:0] lift_r;
  logic [15:0] stride_r;

  logic        eng_start;
  eng_cmd_t    eng_cmd;
  logic        eng_done;
  logic [63:0] eng_result;

  qgft_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (eng_start),
    .cmd    (eng_cmd),
    .done   (eng_done),
    .result (eng_result)
  );

  // per leg geometry from the current phase
  logic [15:0] d;
  logic        in_swing;
  logic [17:0] sw_val;
  logic [16:0] r_len;
  logic [15:0] k_len;
  logic [17:0] st_val;
  logic [17:0] val;
  logic [16:0] half_len;
  logic [33:0] q;
  logic [15:0] sat_q;

  always_comb begin
    d        = gait_phase - start_leg[leg];
    in_swing = d <= swing_fraction;
    sw_val   = {1'b0, d, 1'b0} - {2'b00, swing_fraction};
    r_len    = 17'h10000 - {1'b0, swing_fraction};
    k_len    = d - swing_fraction;
    st_val   = {1'b0, r_len} - {1'b0, k_len, 1'b0};
    val      = in_swing ? sw_val : st_val;
    half_len = ({1'b0, step_length} + 17'd1) >> 1;
    q        = eng_result[33:0];
    if (neg_r) sat_q = (q > 34'd32768) ? 16'h8000 : 16'(-q);
    else       sat_q = (q > 34'd32767) ? 16'h7fff : q[15:0];
  end

  // command for the shared unit in each state
  always_comb begin
    eng_cmd.op = OP_MUL;
    eng_cmd.a  = '0;
    eng_cmd.b  = '0;
    unique case (state)
      S_H2: begin
        eng_cmd.a = {48'd0, lift_height};
        eng_cmd.b = {48'd0, lift_height};
      end
      S_PMUL: begin
        eng_cmd.a = {48'd0, d_r};
        eng_cmd.b = {48'd0, swing_fraction - d_r};
      end
      S_QMUL: begin
        eng_cmd.a = {32'd0, h2};
        eng_cmd.b = {30'd0, res[31:0], 2'b00};
      end
      S_ROOT: begin
        eng_cmd.op = OP_SQRT;
        eng_cmd.a  = res;
      end
      S_LDIV: begin
        eng_cmd.op = OP_DIV;
        eng_cmd.a  = {32'd0, res[31:0]};
        eng_cmd.b  = {48'd0, swing_fraction};
      end
      S_SMUL: begin
        eng_cmd.a = {48'd0, step_length};
        eng_cmd.b = {47'd0, mag_r};
      end
      S_SDIV: begin
        eng_cmd.op = OP_DIV;
        eng_cmd.a  = {30'd0, {res[32:0], 1'b0} + {16'd0, den_r}};
        eng_cmd.b  = {45'd0, den_r, 1'b0};
      end
      default: ;
    endcase
  end

  assign eng_start = !issued && (state == S_H2 || state == S_PMUL || state == S_QMUL ||
                                 state == S_ROOT || state == S_LDIV || state == S_SMUL ||
                                 state == S_SDIV);
  assign s_tready  = (state == S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gait_phase <= '0;
      leg        <= '0;
      issued     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // a taken item clears the output unless the emit state refills it
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      if (eng_start) issued <= 1'b1;
      if (issued && eng_done) begin
        issued <= 1'b0;
        res    <= eng_result;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tdata[0]) begin
            gait_phase <= gait_phase + phase_increment;
            leg        <= '0;
            state      <= S_H2;
          end
        end
        S_H2: begin
          if (issued && eng_done) begin
            h2    <= eng_result[31:0];
            state <= S_LEG;
          end
        end
        S_LEG: begin
          d_r     <= d;
          swing_r <= in_swing;
          neg_r   <= val[17];
          mag_r   <= val[17] ? 17'(-val) : val[16:0];
          den_r   <= in_swing ? {1'b0, swing_fraction, 1'b0} : {r_len, 1'b0};
          lift_r  <= '0;
          if (in_swing && swing_fraction == 16'd0) begin
            stride_r <= 16'(-half_len);
            state    <= S_EMIT;
          end else if (in_swing) begin
            state <= S_PMUL;
          end else begin
            state <= S_SMUL;
          end
        end
        S_PMUL: if (issued && eng_done) state <= S_QMUL;
        S_QMUL: if (issued && eng_done) state <= S_ROOT;
        S_ROOT: if (issued && eng_done) state <= S_LDIV;
        S_LDIV: begin
          if (issued && eng_done) begin
            lift_r <= eng_result[15:0];
            state  <= S_SMUL;
          end
        end
        S_SMUL: if (issued && eng_done) state <= S_SDIV;
        S_SDIV: begin
          if (issued && eng_done) begin
            stride_r <= sat_q;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, swing_r, lift_r, stride_r, leg};
            m_tlast  <= (leg == LAST_LEG);
            if (leg == LAST_LEG) begin
              state <= S_IDLE;
            end else begin
              leg   <= leg + 2'd1;
              state <= S_LEG;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/tb_quadruped_gait_foot_trajectory.sv -----
// ----------------------------------------------------------------------------
// tb_quadruped_gait_foot_trajectory
// Self-checking bench for the gait foot trajectory block: a queue fed driver
// offers tick items, an in-bench gait model predicts the four leg items of
// every tick, and a monitor compares each result item field by field.
// ----------------------------------------------------------------------------
module tb_quadruped_gait_foot_trajectory;
  import qgft_pkg::*;

  typedef struct {
    logic [1:0]         leg;
    logic signed [15:0] stride;
    logic [15:0]        lift;
    logic               swinging;
    logic               last;
  } foot_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [7:0]  s_tdata;   // [0] tick
  logic        m_tvalid, m_tready;
  logic [39:0] m_tdata;   // [1:0] leg, [17:2] stride_offset, [33:18] lift, [34] swinging
  logic        m_tlast;

  quadruped_gait_foot_trajectory dut (.*);

  // gait model state and its copy of the registers
  logic [15:0] mdl_regs [8];
  logic [15:0] mdl_phase;
  foot_t       foot_q [$];
  bit          tick_q [$];
  int          errors = 0;

  // handshake bookkeeping between processes
  bit in_taken  = 0;
  bit src_pause = 0;
  bit no_idle   = 0;
  bit long_req  = 0;
  bit long_started = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int long_cnt = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("quadruped_gait_foot_trajectory test failed");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // round half away from zero, then saturate to 16 bit signed
  function automatic logic signed [15:0] round_sat(input longint num, input longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // largest y with (y*w)^2 <= h^2 * 4d(w-d)
  function automatic logic [15:0] lift_of(input logic [15:0] h, input logic [15:0] w,
                                          input logic [15:0] d);
    logic [63:0] q, p;
    logic [15:0] y, c;
    q = 64'(h) * 64'(h) * (64'd4 * 64'(d) * 64'(w - d));
    y = 0;
    for (int b = 15; b >= 0; b--) begin
      c = y | (16'd1 << b);
      p = 64'(c) * 64'(w);
      if (p * p <= q) y = c;
    end
    return y;
  endfunction

  // advance the gait and queue the four expected leg items
  function automatic void advance_gait();
    logic [15:0] w, d;
    longint l, r, k;
    foot_t f;
    w = mdl_regs[REG_SWING];
    l = longint'(mdl_regs[REG_STEP_LEN]);
    mdl_phase = mdl_phase + mdl_regs[REG_PHASE_INC];
    for (int leg = 0; leg < NUM_LEGS_DEF; leg++) begin
      d = mdl_phase - mdl_regs[REG_START0 + leg];
      f.leg = leg[1:0];
      f.lift = 0;
      f.last = (leg == NUM_LEGS_DEF - 1);
      if (d <= w) begin
        f.swinging = 1;
        if (w == 0) f.stride = round_sat(-l, 2);
        else begin
          f.stride = round_sat((2 * longint'(d) - longint'(w)) * l, 2 * longint'(w));
          f.lift = lift_of(mdl_regs[REG_LIFT_H], w, d);
        end
      end else begin
        f.swinging = 0;
        r = 65536 - longint'(w);
        k = longint'(d) - longint'(w);
        f.stride = round_sat((r - 2 * k) * l, 2 * r);
      end
      foot_q.push_back(f);
    end
  endfunction

  // input acceptance, register writes and result checking
  always @(posedge clk) begin
    foot_t f;
    in_taken = s_tvalid && s_tready && !rst;
    if (rst) begin
      mdl_phase = 0;
      mdl_regs = '{RST_PHASE_INC, RST_SWING, RST_STEP_LEN, RST_LIFT_H,
                   RST_START0, RST_START1, RST_START2, RST_START3};
    end else begin
      if (psel && penable && pwrite && pready) mdl_regs[paddr[4:2]] = pwdata[15:0];
      if (in_taken && s_tdata[0]) advance_gait();
      if (m_tvalid && m_tready) begin
        if (foot_q.size() == 0) report("unexpected item", m_tdata[1:0], -1);
        else begin
          f = foot_q.pop_front();
          if (m_tdata[1:0] != f.leg) report("leg", m_tdata[1:0], f.leg);
          if ($signed(m_tdata[17:2]) != f.stride)
            report("stride_offset", $signed(m_tdata[17:2]), f.stride);
          if (m_tdata[33:18] != f.lift) report("lift", m_tdata[33:18], f.lift);
          if (m_tdata[34] != f.swinging) report("swinging", m_tdata[34], f.swinging);
          if (m_tlast != f.last) report("last", m_tlast, f.last);
        end
      end
    end
  end

  // sender: offers queued tick items with random gaps
  always @(negedge clk) begin
    logic v;
    v = s_tvalid;
    if (rst) v = 0;
    else if (!s_tvalid || in_taken) begin
      v = 0;
      if (src_gap > 0) src_gap--;
      else if (!src_pause && tick_q.size() > 0) begin
        if (!no_idle && $urandom_range(0, 3) == 0) src_gap = $urandom_range(0, 3);
        else begin
          v = 1;
          s_tdata <= {7'd0, tick_q.pop_front()};
        end
      end
    end
    s_tvalid <= v;
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    logic rdy;
    rdy = 1;
    if (long_req && !long_started) begin
      long_started = 1;
      long_cnt = 3000;
    end
    if (long_cnt > 0) begin
      long_cnt--;
      rdy = 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      rdy = 0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      sink_gap = $urandom_range(0, 3);
      rdy = 0;
    end
    m_tready <= rst ? 1'b0 : rdy;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, val};
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    wait (tick_q.size() == 0 && !s_tvalid);
    wait (foot_q.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    logic [15:0] ph;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; m_tready = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset gait, with ignored ticks mixed in
    tick_q = '{1, 0, 1, 1, 0, 0, 1, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
    drain();

    for (int p = 0; p < 11; p++) begin
      ph = mdl_phase;
      case (p)
        0: begin  // zero swing window hit exactly at its start
          write_reg(REG_PHASE_INC, 16'd0); write_reg(REG_SWING, 16'd0);
          write_reg(REG_STEP_LEN, 16'hffff); write_reg(REG_LIFT_H, 16'hffff);
          write_reg(REG_START0, ph); write_reg(REG_START1, 16'(ph + 16'd1));
          write_reg(REG_START2, 16'(ph - 16'd1)); write_reg(REG_START3, ph + 16'h8000);
        end
        1: begin  // full window, half stride saturates at the window end
          write_reg(REG_PHASE_INC, 16'hffff); write_reg(REG_SWING, 16'hffff);
          write_reg(REG_STEP_LEN, 16'hffff); write_reg(REG_LIFT_H, 16'hffff);
          write_reg(REG_START0, ph); write_reg(REG_START1, 16'(ph + 16'd1));
          write_reg(REG_START2, 16'd0); write_reg(REG_START3, 16'hffff);
        end
        2: begin
          write_reg(REG_PHASE_INC, 16'd1); write_reg(REG_SWING, 16'd1);
          write_reg(REG_STEP_LEN, 16'd0); write_reg(REG_LIFT_H, 16'd0);
          write_reg(REG_START0, 16'(ph + 16'd1)); write_reg(REG_START1, 16'(ph + 16'd2));
          write_reg(REG_START2, ph); write_reg(REG_START3, 16'hffff);
        end
        default: begin  // random gait, windows may wrap past one cycle
          write_reg(REG_PHASE_INC, 16'($urandom_range(0, 65535)));
          write_reg(REG_SWING, (p % 3 == 0) ? 16'($urandom_range(65000, 65535))
                                            : 16'($urandom_range(0, 65535)));
          write_reg(REG_STEP_LEN, 16'($urandom_range(0, 65535)));
          write_reg(REG_LIFT_H, 16'($urandom_range(0, 65535)));
          for (int i = 0; i < 4; i++)
            write_reg(3'(REG_START0 + i), 16'($urandom_range(0, 65535)));
        end
      endcase
      if (p == 10) no_idle = 1;
      for (int i = 0; i < 40; i++) tick_q.push_back($urandom_range(0, 3) != 0);
      if (p == 4) long_req = 1;
      if (p == 6) begin
        wait (tick_q.size() < 20);
        src_pause = 1;
        wait (foot_q.size() == 0);
        src_pause = 0;
      end
      drain();
    end

    if (errors == 0) $display("quadruped_gait_foot_trajectory test passed");
    else $display("quadruped_gait_foot_trajectory test failed");
    $finish;
  end

endmodule
